[rtl/imu_prs_pkg.sv]
// ----------------------------------------------------------------------------
// imu_prs_pkg
// Types and constants shared by the IMU packet resync parser.
// ----------------------------------------------------------------------------
package imu_prs_pkg;

  localparam int unsigned PktLen       = 11;
  localparam int unsigned SumLen       = 10;
  localparam logic [3:0]  PKT_LEN      = 4'd11;
  localparam logic [3:0]  SKIP_AFTER   = 4'd10;
  localparam logic [7:0]  HDR_BYTE     = 8'h55;
  localparam logic [7:0]  TYPE_ACC     = 8'h51;
  localparam logic [7:0]  TYPE_GYRO    = 8'h52;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_GYRO = 2'd0,
    KIND_ACC  = 2'd1,
    KIND_BAD  = 2'd2
  } pkt_kind_e;

  // One buffered input byte.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  // One result.
  typedef struct packed {
    pkt_kind_e   kind;
    logic [15:0] axis_x;
    logic [15:0] axis_y;
    logic [15:0] axis_z;
    logic [15:0] good_total;
    logic [15:0] bad_total;
    logic [15:0] resync_total;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

[rtl/imu_prs_in_stage.sv]
// ----------------------------------------------------------------------------
// imu_prs_in_stage
// Input register: holds one received byte until the framer takes it.
// ----------------------------------------------------------------------------
module imu_prs_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rx_valid_i,
  output logic                      rx_ready_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      take_i,
  output imu_prs_pkg::byte_stage_t  stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       accept;

  assign rx_ready_o = !valid_q || take_i;
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

[rtl/imu_prs_framer.sv]
// ----------------------------------------------------------------------------
// imu_prs_framer
// Byte window, skip and saturating counters, header/type/sum check and the
// result register.
// ----------------------------------------------------------------------------
module imu_prs_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  imu_prs_pkg::byte_stage_t  stage_i,
  output logic                      take_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output imu_prs_pkg::result_t      res_o
);

  logic [7:0]  win_q [imu_prs_pkg::PktLen];
  logic [7:0]  win_n [imu_prs_pkg::PktLen];
  logic [3:0]  fill_q, fill_d;
  logic [3:0]  skip_q, skip_d;
  logic [15:0] good_q, good_d;
  logic [15:0] bad_q, bad_d;
  logic [15:0] resync_q, resync_d;
  logic        res_valid_q, res_valid_d;
  imu_prs_pkg::result_t res_q, res_d;

  logic       hdr_ok;
  logic       sum_ok;
  logic       emit;
  logic [7:0] sum_lo, sum_hi, sum;

  // Advance whenever the result register is free or draining this cycle.
  assign take_o = stage_i.valid && (!res_valid_q || res_ready_i);

  always_comb begin
    for (int i = 0; i < imu_prs_pkg::PktLen - 1; i++) begin
      win_n[i] = win_q[i + 1];
    end
    win_n[imu_prs_pkg::PktLen - 1] = stage_i.data;
  end

  // Two half sums keep the adder chain short.
  always_comb begin
    sum_lo = 8'd0;
    sum_hi = 8'd0;
    for (int i = 0; i < imu_prs_pkg::SumLen / 2; i++) begin
      sum_lo = sum_lo + win_n[i];
      sum_hi = sum_hi + win_n[i + imu_prs_pkg::SumLen / 2];
    end
    sum = sum_lo + sum_hi;
  end

  assign hdr_ok = (win_n[0] == imu_prs_pkg::HDR_BYTE) &&
                  ((win_n[1] == imu_prs_pkg::TYPE_ACC) ||
                   (win_n[1] == imu_prs_pkg::TYPE_GYRO));
  assign sum_ok = (sum == win_n[imu_prs_pkg::PktLen - 1]);

  always_comb begin
    fill_d   = fill_q;
    skip_d   = skip_q;
    good_d   = good_q;
    bad_d    = bad_q;
    resync_d = resync_q;
    emit     = 1'b0;
    if (take_o) begin
      if (fill_q != imu_prs_pkg::PKT_LEN) begin
        fill_d = fill_q + 4'd1;
      end
      if (fill_q >= imu_prs_pkg::PKT_LEN - 4'd1) begin
        priority if (skip_q != 4'd0) begin
          skip_d = skip_q - 4'd1;
        end else if (!hdr_ok) begin
          resync_d = imu_prs_pkg::sat_inc(resync_q);
        end else if (sum_ok) begin
          good_d = imu_prs_pkg::sat_inc(good_q);
          skip_d = imu_prs_pkg::SKIP_AFTER;
          emit   = 1'b1;
        end else begin
          bad_d = imu_prs_pkg::sat_inc(bad_q);
          emit  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_d.good_total   = good_d;
    res_d.bad_total    = bad_d;
    res_d.resync_total = resync_d;
    if (sum_ok) begin
      res_d.kind   = (win_n[1] == imu_prs_pkg::TYPE_GYRO) ? imu_prs_pkg::KIND_GYRO
                                                          : imu_prs_pkg::KIND_ACC;
      res_d.axis_x = {win_n[3], win_n[2]};
      res_d.axis_y = {win_n[5], win_n[4]};
      res_d.axis_z = {win_n[7], win_n[6]};
    end else begin
      res_d.kind   = imu_prs_pkg::KIND_BAD;
      res_d.axis_x = 16'd0;
      res_d.axis_y = 16'd0;
      res_d.axis_z = 16'd0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < imu_prs_pkg::PktLen; i++) begin
        win_q[i] <= 8'd0;
      end
      fill_q      <= 4'd0;
      skip_q      <= 4'd0;
      good_q      <= 16'd0;
      bad_q       <= 16'd0;
      resync_q    <= 16'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        win_q <= win_n;
      end
      fill_q      <= fill_d;
      skip_q      <= skip_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      resync_q    <= resync_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/imu_packet_resync_parser_core.sv]
// ----------------------------------------------------------------------------
// imu_packet_resync_parser_core
// Resynchronizing parser for 11-byte sensor packets with an 8-bit sum check.
// ----------------------------------------------------------------------------
// Input channel rx_*: one received byte per transaction. Output channel
// pkt_*: one transaction per checked window that is either a good packet
// (gyro or accelerometer, with three signed axis words) or a checksum
// failure (axis words zero). Bytes that only fill the window, fall in the
// skip after a good packet, or fail the header/type test give no output;
// the last of these only bumps resync_total, seen with the next result.
// Every result carries the three saturating totals after its byte.
// Throughput: one byte per cycle while pkt_ready_i keeps the output free. A
// byte is held in the input register and its result is registered in the
// result register, which drives pkt_valid_o.
// While a result waits, at most one more byte is taken (only if the input
// register is empty); then rx_ready_o stays low until pkt_ready_i frees the
// output, even for bytes that would give no result.
// Reset clears the window, fill and skip counts and all totals; the first
// check happens on the eleventh byte after reset.
// ----------------------------------------------------------------------------
module imu_packet_resync_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               pkt_valid_o,
  input  logic               pkt_ready_i,
  output logic [1:0]         packet_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o,
  output logic [15:0]        good_total_o,
  output logic [15:0]        bad_total_o,
  output logic [15:0]        resync_total_o
);

  imu_prs_pkg::byte_stage_t stage;
  imu_prs_pkg::result_t     res;
  logic                     take;

  imu_prs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .stage_o    (stage)
  );

  imu_prs_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .take_o      (take),
    .res_valid_o (pkt_valid_o),
    .res_ready_i (pkt_ready_i),
    .res_o       (res)
  );

  assign packet_kind_o  = res.kind;
  assign axis_x_o       = res.axis_x;
  assign axis_y_o       = res.axis_y;
  assign axis_z_o       = res.axis_z;
  assign good_total_o   = res.good_total;
  assign bad_total_o    = res.bad_total;
  assign resync_total_o = res.resync_total;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU packet resync parser core.
// ----------------------------------------------------------------------------
// Received bytes are queued by the stimulus process and sent by a clocked
// driver. Every accepted byte runs through a byte-level packet predictor that
// queues the expected packet results. A clocked monitor compares each packet
// transaction field by field. Stimulus covers directed extremes, random
// framed traffic with noise and broken frames under varying backpressure,
// and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned HoldLen = 400;
  localparam int unsigned QueueCap = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_valid_i = 1'b0;
  logic rx_ready_o;
  logic [7:0] rx_byte_i = 8'd0;
  logic pkt_valid_o;
  logic pkt_ready_i = 1'b0;
  logic [1:0] packet_kind_o;
  logic signed [15:0] axis_x_o;
  logic signed [15:0] axis_y_o;
  logic signed [15:0] axis_z_o;
  logic [15:0] good_total_o;
  logic [15:0] bad_total_o;
  logic [15:0] resync_total_o;

  // Byte-level parser state mirrored by the predictor
  logic [7:0] win_q [imu_prs_pkg::PktLen];
  logic [3:0] win_fill;
  logic [3:0] skip_cnt;
  logic [15:0] good_cnt;
  logic [15:0] bad_cnt;
  logic [15:0] resync_cnt;

  logic [7:0] pend_bytes_q [$];
  imu_prs_pkg::result_t pkt_exp_q [$];
  imu_prs_pkg::result_t want_r;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int queued_bytes = 0;
  int mismatches = 0;
  bit hold_go = 1'b0;
  int unsigned hold_left;

  imu_packet_resync_parser_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .pkt_valid_o   (pkt_valid_o),
    .pkt_ready_i   (pkt_ready_i),
    .packet_kind_o (packet_kind_o),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .good_total_o  (good_total_o),
    .bad_total_o   (bad_total_o),
    .resync_total_o(resync_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] count_up_sat(input logic [15:0] v);
    return (v == imu_prs_pkg::CNT_MAX) ? v : v + 16'd1;
  endfunction

  // Shift one accepted byte into the mirrored window and queue any result
  function automatic void predict_packet(input logic [7:0] b);
    logic [7:0] sum;
    imu_prs_pkg::result_t r;
    for (int i = 0; i < imu_prs_pkg::PktLen - 1; i++) win_q[i] = win_q[i + 1];
    win_q[imu_prs_pkg::PktLen - 1] = b;
    if (win_fill < imu_prs_pkg::PKT_LEN) win_fill = win_fill + 4'd1;
    if (win_fill < imu_prs_pkg::PKT_LEN) return;
    if (skip_cnt != 4'd0) begin
      skip_cnt = skip_cnt - 4'd1;
      return;
    end
    if (win_q[0] != imu_prs_pkg::HDR_BYTE ||
        (win_q[1] != imu_prs_pkg::TYPE_ACC && win_q[1] != imu_prs_pkg::TYPE_GYRO)) begin
      resync_cnt = count_up_sat(resync_cnt);
      return;
    end
    sum = 8'd0;
    for (int i = 0; i < imu_prs_pkg::SumLen; i++) sum = sum + win_q[i];
    if (sum == win_q[imu_prs_pkg::PktLen - 1]) begin
      good_cnt = count_up_sat(good_cnt);
      skip_cnt = imu_prs_pkg::SKIP_AFTER;
      r.kind = (win_q[1] == imu_prs_pkg::TYPE_GYRO) ? imu_prs_pkg::KIND_GYRO
                                                    : imu_prs_pkg::KIND_ACC;
      r.axis_x = {win_q[3], win_q[2]};
      r.axis_y = {win_q[5], win_q[4]};
      r.axis_z = {win_q[7], win_q[6]};
    end else begin
      bad_cnt = count_up_sat(bad_cnt);
      r.kind = imu_prs_pkg::KIND_BAD;
      r.axis_x = 16'd0;
      r.axis_y = 16'd0;
      r.axis_z = 16'd0;
    end
    r.good_total = good_cnt;
    r.bad_total = bad_cnt;
    r.resync_total = resync_cnt;
    pkt_exp_q.push_back(r);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 'h%h, actual 'h%h", $time, what, want, got);
    end
  endfunction

  // Byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i <= 8'd0;
    end else begin
      if (rx_valid_i && rx_ready_o) predict_packet(rx_byte_i);
      if (!rx_valid_i || rx_ready_o) begin
        if (pend_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          rx_valid_i <= 1'b1;
          rx_byte_i <= pend_bytes_q.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HoldLen;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Packet monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_ready_i <= 1'b0;
    end else begin
      if (pkt_valid_o && pkt_ready_i) begin
        if (pkt_exp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected packet transaction, expected none, actual kind %0d",
                   $time, packet_kind_o);
        end else begin
          want_r = pkt_exp_q.pop_front();
          check_field("packet_kind", {14'd0, want_r.kind}, {14'd0, packet_kind_o});
          check_field("axis_x", want_r.axis_x, axis_x_o);
          check_field("axis_y", want_r.axis_y, axis_y_o);
          check_field("axis_z", want_r.axis_z, axis_z_o);
          check_field("good_total", want_r.good_total, good_total_o);
          check_field("bad_total", want_r.bad_total, bad_total_o);
          check_field("resync_total", want_r.resync_total, resync_total_o);
        end
      end
      pkt_ready_i <= !hold_go && hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while (pend_bytes_q.size() >= QueueCap) @(negedge clk_i);
    pend_bytes_q.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_frame(input logic [7:0] kind_b, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z, input bit corrupt);
    logic [7:0] pkt [imu_prs_pkg::PktLen];
    logic [7:0] sum;
    pkt[0] = imu_prs_pkg::HDR_BYTE;
    pkt[1] = kind_b;
    pkt[2] = x[7:0];
    pkt[3] = x[15:8];
    pkt[4] = y[7:0];
    pkt[5] = y[15:8];
    pkt[6] = z[7:0];
    pkt[7] = z[15:8];
    pkt[8] = 8'($urandom);
    pkt[9] = 8'($urandom);
    sum = 8'd0;
    for (int i = 0; i < imu_prs_pkg::SumLen; i++) sum = sum + pkt[i];
    pkt[10] = corrupt ? sum ^ 8'($urandom_range(255, 1)) : sum;
    foreach (pkt[i]) push_byte(pkt[i]);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_type();
    return $urandom_range(1) ? imu_prs_pkg::TYPE_GYRO : imu_prs_pkg::TYPE_ACC;
  endfunction

  // Wait until every queued byte is sent and every expected packet has come
  task automatic drain();
    while (pend_bytes_q.size() != 0 || rx_valid_i || pkt_exp_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_random(input int n, input int tx_pct, input int rx_pct);
    int stop_at;
    int pick;
    logic [7:0] kind_b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = queued_bytes + n;
    while (queued_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_frame(rand_type(), rand_word(), rand_word(), rand_word(), 1'b0);
      end else if (pick < 70) begin
        push_frame(rand_type(), rand_word(), rand_word(), rand_word(), 1'b1);
      end else if (pick < 80) begin
        do kind_b = 8'($urandom);
        while (kind_b == imu_prs_pkg::TYPE_ACC || kind_b == imu_prs_pkg::TYPE_GYRO);
        push_frame(kind_b, rand_word(), rand_word(), rand_word(), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        // frame cut short, then the stream carries on
        push_byte(imu_prs_pkg::HDR_BYTE);
        push_byte(rand_type());
        repeat ($urandom_range(8, 0)) push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(6, 1))
          push_byte(($urandom_range(3) == 0) ? imu_prs_pkg::HDR_BYTE : 8'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < imu_prs_pkg::PktLen; i++) win_q[i] = 8'd0;
    win_fill = 4'd0;
    skip_cnt = 4'd0;
    good_cnt = 16'd0;
    bad_cnt = 16'd0;
    resync_cnt = 16'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: signed extremes, failed sum whose payload holds a header
    // followed by an invalid type, then a clean accelerometer frame.
    push_frame(imu_prs_pkg::TYPE_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
    push_frame(imu_prs_pkg::TYPE_ACC, 16'h0055, 16'h0000, 16'h0000, 1'b1);
    push_frame(imu_prs_pkg::TYPE_ACC, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    drain();

    run_random(480, 35, 66);
    drain();
    run_random(480, 66, 35);
    drain();

    // Output held off while bytes keep coming, so the input side backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    @(negedge clk_i);
    hold_go = 1'b0;
    repeat (6) push_frame(rand_type(), rand_word(), rand_word(), rand_word(), 1'b0);
    run_random(470, 0, 0);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
